// ===== rtl/core/glob_name_matcher_macros.svh =====
// ----------------------------------------------------------------------------
// glob_name_matcher_macros.svh
// assertion shorthands shared by the glob name matcher rtl
// ----------------------------------------------------------------------------
`ifndef GLOB_NAME_MATCHER_MACROS_SVH
`define GLOB_NAME_MATCHER_MACROS_SVH

// same-cycle implication, held off during reset
`define GNM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gnm: same-cycle check failed");

// next-cycle implication, held off during reset
`define GNM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gnm: next-cycle check failed");

`endif

// ===== rtl/core/gnm_pkg.sv =====
// ----------------------------------------------------------------------------
// gnm_pkg
// shared constants and types of the glob name matcher
// ----------------------------------------------------------------------------
package gnm_pkg;

  localparam int unsigned PatternBytes = 48;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned LenW         = 6;
  localparam int unsigned ByteW        = 8;

  // pattern metacharacters
  localparam logic [ByteW-1:0] ChEsc   = 8'h5C;
  localparam logic [ByteW-1:0] ChAny   = 8'h3F;
  localparam logic [ByteW-1:0] ChStar  = 8'h2A;
  localparam logic [ByteW-1:0] ChOpen  = 8'h5B;
  localparam logic [ByteW-1:0] ChNot   = 8'h21;
  localparam logic [ByteW-1:0] ChClose = 8'h5D;
  localparam logic [ByteW-1:0] ChDash  = 8'h2D;

  // classification of the current pattern byte against the name byte
  typedef struct packed {
    logic is_esc;
    logic is_any;
    logic is_star;
    logic is_open;
    logic is_not;
    logic is_close;
    logic is_dash;
    logic eq;
    logic in_range;
    logic c_dash;
  } char_flags_t;

  // verdict handed from the sequencer to the output register
  typedef struct packed {
    logic valid;
    logic match;
    logic supermatch;
  } rpt_t;

endpackage

// ===== rtl/core/gnm_if.sv =====
// ----------------------------------------------------------------------------
// gnm_if
// valid/ready channels of the glob name matcher
// ----------------------------------------------------------------------------
interface gnm_name_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output name_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input name_byte, input has_byte, input last,
                  output ready);
endinterface

interface gnm_result_if;
  logic valid;
  logic ready;
  logic match;
  logic supermatch;

  modport source (output valid, output match, output supermatch, input ready);
  modport sink   (input valid, input match, input supermatch, output ready);
endinterface

// ===== rtl/core/glob_name_matcher.sv =====
// ----------------------------------------------------------------------------
// glob_name_matcher
// matches streamed name bytes against a configured glob pattern
// ----------------------------------------------------------------------------
// usage:
//   name_i carries one word per name byte (has_byte=1) or an empty marker
//   (has_byte=0); last=1 closes the name. result_o gives one word per name:
//   match, and supermatch when a double star decided it.
//   the pattern (bytes in pattern words, lowest byte first) and its length
//   are written through the cfg port while no name is in flight.
// walk:
//   a word is taken only while the sequencer is idle, then the pattern is
//   walked one byte per cycle through a single compare unit; an empty word,
//   or any word once the verdict is known, walks no pattern byte. the
//   closing word also walks trailing stars, one a cycle, and hands the
//   verdict to the output register.
// reset:
//   clears pattern, length, match state and the output register.
// stall:
//   the result waits in the output register; the next name proceeds and
//   only its verdict handoff waits for a free output register.
// ----------------------------------------------------------------------------
`include "glob_name_matcher_macros.svh"

module glob_name_matcher #(
  parameter int unsigned PATTERN_BYTES = gnm_pkg::PatternBytes,
  localparam int unsigned NumWords = (PATTERN_BYTES + 7) / 8,
  localparam int unsigned CfgIdxW  = $clog2(NumWords + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxW-1:0]           cfg_idx_i,
  input  logic [gnm_pkg::CfgDataW-1:0] cfg_data_i,
  gnm_name_if.sink                     name_i,
  gnm_result_if.source                 result_o
);
  import gnm_pkg::*;

  localparam int unsigned PosW = $clog2(PATTERN_BYTES + 1);

  // pattern read port and its length
  logic [PosW-1:0]  rd_addr;
  logic [ByteW-1:0] rd_byte;
  logic [PosW-1:0]  plen;

  // shared compare unit operands and flags
  logic [ByteW-1:0] cur_c;
  logic [ByteW-1:0] prev_c;
  char_flags_t      flags;

  // verdict handoff and output register
  rpt_t rpt;
  logic out_free;
  logic out_valid_q;
  logic match_q;
  logic super_q;

  gnm_pattern_regs #(
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rd_addr_i  (rd_addr),
    .rd_byte_o  (rd_byte),
    .plen_o     (plen)
  );

  gnm_char_unit u_char (
    .pat_i   (rd_byte),
    .c_i     (cur_c),
    .prev_i  (prev_c),
    .flags_o (flags)
  );

  gnm_sequencer #(
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (name_i.valid),
    .in_ready_o  (name_i.ready),
    .name_byte_i (name_i.name_byte),
    .has_byte_i  (name_i.has_byte),
    .last_i      (name_i.last),
    .out_free_i  (out_free),
    .rpt_o       (rpt),
    .rd_addr_o   (rd_addr),
    .rd_byte_i   (rd_byte),
    .plen_i      (plen),
    .flags_i     (flags),
    .c_o         (cur_c),
    .prev_o      (prev_c)
  );

  // output register is free when empty or drained this cycle
  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rpt.valid) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded on handoff only
  always_ff @(posedge clk_i) begin
    if (rpt.valid) begin
      match_q <= rpt.match;
      super_q <= rpt.supermatch;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.match      = match_q;
  assign result_o.supermatch = super_q;

  // a handoff never overwrites a result that is still waiting
  `GNM_ASSERT_NOW(a_handoff_into_free_reg, clk_i, rst_ni, rpt.valid,
    !out_valid_q || result_o.ready)

endmodule

// ===== rtl/core/gnm_pattern_regs.sv =====
// ----------------------------------------------------------------------------
// gnm_pattern_regs
// pattern word and length registers with one byte read port
// ----------------------------------------------------------------------------
module gnm_pattern_regs #(
  parameter int unsigned PATTERN_BYTES = gnm_pkg::PatternBytes,
  localparam int unsigned NumWords = (PATTERN_BYTES + 7) / 8,
  localparam int unsigned CfgIdxW  = $clog2(NumWords + 1),
  localparam int unsigned PosW     = $clog2(PATTERN_BYTES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxW-1:0]            cfg_idx_i,
  input  logic [gnm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [PosW-1:0]               rd_addr_i,
  output logic [gnm_pkg::ByteW-1:0]     rd_byte_o,
  output logic [PosW-1:0]               plen_o
);
  import gnm_pkg::*;

  localparam int unsigned WIdxW = (NumWords > 1) ? $clog2(NumWords) : 1;

  logic [CfgDataW-1:0] words_q [NumWords];
  logic [LenW-1:0]     len_q;
  logic [CfgDataW-1:0] rd_word;
  logic [7:0]          len_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NumWords); i++) begin
        words_q[i] <= '0;
      end
      len_q <= '0;
    end else if (cfg_we_i) begin
      if (int'(cfg_idx_i) < int'(NumWords)) begin
        words_q[cfg_idx_i[WIdxW-1:0]] <= cfg_data_i;
      end else if (int'(cfg_idx_i) == int'(NumWords)) begin
        len_q <= cfg_data_i[LenW-1:0];
      end
    end
  end

  // bytes past the buffer read as zero
  always_comb begin
    rd_word   = words_q[rd_addr_i[3 +: WIdxW]];
    rd_byte_o = '0;
    if (int'(rd_addr_i) < int'(PATTERN_BYTES)) begin
      rd_byte_o = ByteW'(rd_word >> {rd_addr_i[2:0], 3'b000});
    end
  end

  // length saturates at the buffer size
  always_comb begin
    len_w = 8'(len_q);
    if (len_w > 8'(PATTERN_BYTES)) begin
      plen_o = PosW'(PATTERN_BYTES);
    end else begin
      plen_o = PosW'(len_q);
    end
  end

endmodule

// ===== rtl/core/gnm_char_unit.sv =====
// ----------------------------------------------------------------------------
// gnm_char_unit
// shared compare unit: classifies one pattern byte against the name byte
// ----------------------------------------------------------------------------
module gnm_char_unit (
  input  logic [gnm_pkg::ByteW-1:0] pat_i,
  input  logic [gnm_pkg::ByteW-1:0] c_i,
  input  logic [gnm_pkg::ByteW-1:0] prev_i,
  output gnm_pkg::char_flags_t      flags_o
);
  import gnm_pkg::*;

  always_comb begin
    flags_o.is_esc   = (pat_i == ChEsc);
    flags_o.is_any   = (pat_i == ChAny);
    flags_o.is_star  = (pat_i == ChStar);
    flags_o.is_open  = (pat_i == ChOpen);
    flags_o.is_not   = (pat_i == ChNot);
    flags_o.is_close = (pat_i == ChClose);
    flags_o.is_dash  = (pat_i == ChDash);
    flags_o.eq       = (pat_i == c_i);
    // inclusive range, prev is the low end and the pattern byte the high end
    flags_o.in_range = (c_i >= prev_i) && (c_i <= pat_i);
    flags_o.c_dash   = (c_i == ChDash);
  end

endmodule

// ===== rtl/core/gnm_sequencer.sv =====
// ----------------------------------------------------------------------------
// gnm_sequencer
// walks the pattern one byte per cycle for each accepted name word
// ----------------------------------------------------------------------------
`include "glob_name_matcher_macros.svh"

module gnm_sequencer #(
  parameter int unsigned PATTERN_BYTES = gnm_pkg::PatternBytes,
  localparam int unsigned PosW = $clog2(PATTERN_BYTES + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [gnm_pkg::ByteW-1:0] name_byte_i,
  input  logic                      has_byte_i,
  input  logic                      last_i,
  input  logic                      out_free_i,
  output gnm_pkg::rpt_t             rpt_o,
  output logic [PosW-1:0]           rd_addr_o,
  input  logic [gnm_pkg::ByteW-1:0] rd_byte_i,
  input  logic [PosW-1:0]           plen_i,
  input  gnm_pkg::char_flags_t      flags_i,
  output logic [gnm_pkg::ByteW-1:0] c_o,
  output logic [gnm_pkg::ByteW-1:0] prev_o
);
  import gnm_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FEED    = 4'd1;
  localparam logic [3:0] S_STAR2   = 4'd2;
  localparam logic [3:0] S_PLAIN   = 4'd3;
  localparam logic [3:0] S_ESC     = 4'd4;
  localparam logic [3:0] S_CLS_NOT = 4'd5;
  localparam logic [3:0] S_CLS     = 4'd6;
  localparam logic [3:0] S_CLS_HI  = 4'd7;
  localparam logic [3:0] S_END     = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [PosW-1:0]  ptr_q, ptr_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             star_q, star_d;
  logic             known_q, known_d;
  logic             vmatch_q, vmatch_d;
  logic             vsuper_q, vsuper_d;
  logic [ByteW-1:0] c_q, c_d;
  logic             has_q, has_d;
  logic             last_q, last_d;
  logic             inv_q, inv_d;
  logic             hit_q, hit_d;
  logic             hprev_q, hprev_d;
  logic [ByteW-1:0] prev_q, prev_d;

  logic             done;
  logic [PosW-1:0]  nxt;
  logic             ptr_lt_l;
  logic             nxt_lt_l;

  assign rd_addr_o  = ptr_q;
  assign c_o        = c_q;
  assign prev_o     = prev_q;
  assign in_ready_o = (state_q == S_IDLE);

  assign nxt      = ptr_q + PosW'(1);
  assign ptr_lt_l = (ptr_q < plen_i);
  assign nxt_lt_l = ((PosW+1)'(ptr_q) + (PosW+1)'(1)) < (PosW+1)'(plen_i);

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    pos_d    = pos_q;
    star_d   = star_q;
    known_d  = known_q;
    vmatch_d = vmatch_q;
    vsuper_d = vsuper_q;
    c_d      = c_q;
    has_d    = has_q;
    last_d   = last_q;
    inv_d    = inv_q;
    hit_d    = hit_q;
    hprev_d  = hprev_q;
    prev_d   = prev_q;
    done     = 1'b0;
    rpt_o    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          c_d     = name_byte_i;
          has_d   = has_byte_i;
          last_d  = last_i;
          ptr_d   = pos_q;
          state_d = S_FEED;
        end
      end
      S_FEED: begin
        if (!has_q || known_q) begin
          done = 1'b1;
        end else if (star_q) begin
          // skipping until the byte equals the character after the star
          if (flags_i.eq) begin
            star_d  = 1'b0;
            state_d = S_PLAIN;
          end else begin
            done = 1'b1;
          end
        end else if (!ptr_lt_l) begin
          known_d  = 1'b1;
          vmatch_d = 1'b0;
          vsuper_d = 1'b0;
          done     = 1'b1;
        end else if (flags_i.is_star) begin
          ptr_d   = nxt;
          state_d = S_STAR2;
        end else begin
          state_d = S_PLAIN;
        end
      end
      S_STAR2: begin
        if (ptr_lt_l && flags_i.is_star) begin
          known_d  = 1'b1;
          vmatch_d = 1'b1;
          vsuper_d = 1'b1;
          done     = 1'b1;
        end else if (!ptr_lt_l) begin
          known_d  = 1'b1;
          vmatch_d = 1'b1;
          vsuper_d = 1'b0;
          done     = 1'b1;
        end else begin
          pos_d = ptr_q;
          if (flags_i.eq) begin
            state_d = S_PLAIN;
          end else begin
            star_d = 1'b1;
            done   = 1'b1;
          end
        end
      end
      S_PLAIN: begin
        if (flags_i.is_esc) begin
          ptr_d   = nxt;
          state_d = S_ESC;
        end else if (flags_i.is_any) begin
          pos_d = nxt;
          done  = 1'b1;
        end else if (flags_i.is_open) begin
          ptr_d   = nxt;
          inv_d   = 1'b0;
          hit_d   = 1'b0;
          hprev_d = 1'b0;
          state_d = S_CLS_NOT;
        end else begin
          if (flags_i.eq) begin
            pos_d = nxt;
          end else begin
            known_d  = 1'b1;
            vmatch_d = 1'b0;
            vsuper_d = 1'b0;
          end
          done = 1'b1;
        end
      end
      S_ESC: begin
        // a dangling escape fails here too
        if (ptr_lt_l && flags_i.eq) begin
          pos_d = nxt;
        end else begin
          known_d  = 1'b1;
          vmatch_d = 1'b0;
          vsuper_d = 1'b0;
        end
        done = 1'b1;
      end
      S_CLS_NOT: begin
        if (ptr_lt_l && flags_i.is_not) begin
          inv_d = 1'b1;
          ptr_d = nxt;
        end
        state_d = S_CLS;
      end
      S_CLS: begin
        if (ptr_lt_l && !flags_i.is_close) begin
          if (flags_i.is_dash && hprev_q && nxt_lt_l) begin
            ptr_d   = nxt;
            state_d = S_CLS_HI;
          end else begin
            if (flags_i.eq) begin
              hit_d = 1'b1;
            end
            prev_d  = rd_byte_i;
            hprev_d = 1'b1;
            ptr_d   = nxt;
          end
        end else begin
          // consume the closing bracket when there is one
          if ((hit_q != inv_q)) begin
            pos_d = ptr_lt_l ? nxt : ptr_q;
          end else begin
            known_d  = 1'b1;
            vmatch_d = 1'b0;
            vsuper_d = 1'b0;
          end
          done = 1'b1;
        end
      end
      S_CLS_HI: begin
        if (!flags_i.is_close) begin
          if (flags_i.in_range) begin
            hit_d = 1'b1;
          end
          hprev_d = 1'b0;
          ptr_d   = nxt;
        end else begin
          // dash before the closing bracket is literal
          if (flags_i.c_dash) begin
            hit_d = 1'b1;
          end
          prev_d  = ChDash;
          hprev_d = 1'b1;
        end
        state_d = S_CLS;
      end
      S_END: begin
        if (!known_q && !star_q && ptr_lt_l && flags_i.is_star) begin
          ptr_d = nxt;
        end else if (out_free_i) begin
          rpt_o.valid = 1'b1;
          if (known_q) begin
            rpt_o.match      = vmatch_q;
            rpt_o.supermatch = vsuper_q;
          end else if (star_q) begin
            rpt_o.match      = 1'b0;
            rpt_o.supermatch = 1'b0;
          end else begin
            rpt_o.match      = (ptr_q == plen_i);
            rpt_o.supermatch = 1'b0;
          end
          pos_d    = '0;
          star_d   = 1'b0;
          known_d  = 1'b0;
          vmatch_d = 1'b0;
          vsuper_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done) begin
      if (last_q) begin
        ptr_d   = pos_d;
        state_d = S_END;
      end else begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ptr_q    <= '0;
      pos_q    <= '0;
      star_q   <= 1'b0;
      known_q  <= 1'b0;
      vmatch_q <= 1'b0;
      vsuper_q <= 1'b0;
      has_q    <= 1'b0;
      last_q   <= 1'b0;
      inv_q    <= 1'b0;
      hit_q    <= 1'b0;
      hprev_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      pos_q    <= pos_d;
      star_q   <= star_d;
      known_q  <= known_d;
      vmatch_q <= vmatch_d;
      vsuper_q <= vsuper_d;
      has_q    <= has_d;
      last_q   <= last_d;
      inv_q    <= inv_d;
      hit_q    <= hit_d;
      hprev_q  <= hprev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    prev_q <= prev_d;
  end

  `GNM_ASSERT_NOW(a_star_vs_verdict, clk_i, rst_ni, star_q, !known_q)
  `GNM_ASSERT_NOW(a_super_implies_match, clk_i, rst_ni, vsuper_q, vmatch_q)
  `GNM_ASSERT_NEXT(a_clear_after_report, clk_i, rst_ni, rpt_o.valid,
    (pos_q == '0) && !known_q && !star_q)

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the glob name matcher
// ----------------------------------------------------------------------------
// runs a series of patterns through the configuration port: first a short
// directed set (escapes, '?', stars, double stars, bracket classes, byte
// extremes, length saturation), then generated patterns with names built to
// follow them and then disturbed. every accepted name word goes through a
// local model of the matcher, and every result word is compared with the
// oldest verdict still waiting.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gnm_pkg::*;

  localparam int unsigned NumWords    = (PatternBytes + 7) / 8;
  localparam int unsigned CfgIdxW     = $clog2(NumWords + 1);
  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned RandomWords = 1750;
  localparam int unsigned MaxReports  = 10;
  // settle wait after the last verdict, scaled with the buffer size
  localparam int unsigned SettleCycles = 2 * PatternBytes + 10;
  localparam int unsigned MaxCycles    = 800_000;

  // register map of the configuration port
  localparam logic [CfgIdxW-1:0] RegWord0  = '0;
  localparam logic [CfgIdxW-1:0] RegLength = CfgIdxW'(NumWords);

  localparam logic [ByteW-1:0] LetterA = "a";

  // receiver ready patterns
  typedef enum int unsigned {RxOpen, RxRandom, RxPeriodic, RxSparse} rx_mode_e;

  typedef struct packed {
    logic match;
    logic supermatch;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  gnm_name_if   name_if ();
  gnm_result_if result_if ();

  glob_name_matcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .name_i     (name_if),
    .result_o   (result_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // matcher model: pattern copy, per-name walk state, pending verdicts
  // --------------------------------------------------------------------------
  logic [CfgDataW-1:0] pat_word_q [NumWords];
  logic [LenW-1:0]     pat_len_q;
  int unsigned         cur_pos;
  bit                  star_seeking;
  bit                  decided;
  bit                  dec_match;
  bit                  dec_super;
  verdict_t            expected_verdicts [$];

  int unsigned error_count;
  int unsigned verdicts_seen;

  // staging area for the next pattern and the name under construction
  logic [ByteW-1:0] staged_pat [PatternBytes];
  int unsigned      staged_len;
  logic [ByteW-1:0] name_buf [$];

  // sender shaping
  bit          steady_sender;
  bit          idle_noise;
  int unsigned burst_left;

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MaxReports) $display("error: %s", msg);
  endfunction

  function automatic logic [ByteW-1:0] pat_byte(int unsigned i);
    if (i >= PatternBytes) return '0;
    return pat_word_q[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // length register saturates at the buffer size
  function automatic int unsigned eff_len(logic [LenW-1:0] raw);
    return (raw > PatternBytes) ? PatternBytes : int'(raw);
  endfunction

  function automatic void conclude(bit m, bit s);
    decided   = 1'b1;
    dec_match = m;
    dec_super = s;
  endfunction

  // one pattern element (not a star) at cur_pos against name byte c
  function automatic void match_element(logic [ByteW-1:0] c, int unsigned len);
    int unsigned      pos;
    logic [ByteW-1:0] p, q, prev, hi;
    bit               invert, hit, have_prev;
    pos       = cur_pos;
    p         = pat_byte(pos);
    invert    = 1'b0;
    hit       = 1'b0;
    have_prev = 1'b0;
    prev      = '0;
    if (p == ChEsc) begin
      pos++;
      if (pos < len && pat_byte(pos) == c) cur_pos = pos + 1;
      else conclude(1'b0, 1'b0);
    end else if (p == ChAny) begin
      cur_pos = pos + 1;
    end else if (p == ChOpen) begin
      pos++;
      if (pos < len && pat_byte(pos) == ChNot) begin
        invert = 1'b1;
        pos++;
      end
      while (pos < len && pat_byte(pos) != ChClose) begin
        q = pat_byte(pos);
        // a dash is a range only between a class byte and a non-closing byte
        if (q == ChDash && have_prev && pos + 1 < len && pat_byte(pos + 1) != ChClose) begin
          hi = pat_byte(pos + 1);
          if (c >= prev && c <= hi) hit = 1'b1;
          have_prev = 1'b0;
          pos += 2;
        end else begin
          if (c == q) hit = 1'b1;
          prev      = q;
          have_prev = 1'b1;
          pos++;
        end
      end
      if (pos < len) pos++;  // closing bracket
      if (hit != invert) cur_pos = pos;
      else conclude(1'b0, 1'b0);
    end else begin
      if (p == c) cur_pos = pos + 1;
      else conclude(1'b0, 1'b0);
    end
  endfunction

  // advance the model by one accepted name word
  function automatic void predict_verdict(logic [ByteW-1:0] c, logic has, logic is_last);
    int unsigned len, nx, pos;
    bit          m, s;
    len = eff_len(pat_len_q);
    if (has && !decided) begin
      if (star_seeking) begin
        if (c == pat_byte(cur_pos)) begin
          star_seeking = 1'b0;
          match_element(c, len);
        end
      end else if (cur_pos >= len) begin
        conclude(1'b0, 1'b0);
      end else if (pat_byte(cur_pos) == ChStar) begin
        nx = cur_pos + 1;
        if (nx < len && pat_byte(nx) == ChStar) conclude(1'b1, 1'b1);
        else if (nx >= len) conclude(1'b1, 1'b0);
        else begin
          cur_pos = nx;
          if (c == pat_byte(nx)) match_element(c, len);
          else star_seeking = 1'b1;
        end
      end else begin
        match_element(c, len);
      end
    end
    if (is_last) begin
      if (decided) begin
        m = dec_match;
        s = dec_super;
      end else if (star_seeking) begin
        m = 1'b0;
        s = 1'b0;
      end else begin
        // trailing stars may still be skipped at the end of the name
        pos = cur_pos;
        while (pos < len && pat_byte(pos) == ChStar) pos++;
        m = (pos == len);
        s = 1'b0;
      end
      expected_verdicts.push_back('{match: m, supermatch: s});
      cur_pos      = 0;
      star_seeking = 1'b0;
      decided      = 1'b0;
      dec_match    = 1'b0;
      dec_super    = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // configuration and name word drivers (called at a falling edge)
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == RegLength) pat_len_q = data[LenW-1:0];
    else pat_word_q[idx] = data;
    @(negedge clk_i);
  endtask

  // write every pattern word from the staging area, then the length
  task automatic commit_pattern(input logic [LenW-1:0] len_val);
    logic [CfgDataW-1:0] word;
    for (int w = 0; w < NumWords; w++) begin
      for (int b = 0; b < 8; b++) begin
        word[b * 8 +: 8] = (w * 8 + b < PatternBytes) ? staged_pat[w * 8 + b] : 8'h00;
      end
      write_reg(RegWord0 + CfgIdxW'(w), word);
    end
    write_reg(RegLength, CfgDataW'(len_val));
    cfg_we_i <= 1'b0;
  endtask

  // one word on the name channel; burst and gap shaping happens here
  task automatic push_word(input logic [ByteW-1:0] b, input logic has, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        name_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    name_if.valid     <= 1'b1;
    name_if.name_byte <= b;
    name_if.has_byte  <= has;
    name_if.last      <= is_last;
    @(posedge clk_i);
    while (!name_if.ready) @(posedge clk_i);
    predict_verdict(b, has, is_last);
    @(negedge clk_i);
  endtask

  // send name_buf as one name; an empty buffer becomes an empty-name word
  task automatic send_name_buf();
    int unsigned n;
    n = name_buf.size();
    if (n == 0) begin
      push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else begin
      for (int k = 0; k < n; k++) begin
        if (idle_noise && $urandom_range(0, 9) == 0) begin
          push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        push_word(name_buf[k], 1'b1, k == n - 1);
      end
    end
  endtask

  // quiet the sender, wait for every verdict, then let the block settle
  task automatic drain_block();
    name_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_verdicts.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // pattern and name construction
  // --------------------------------------------------------------------------
  function automatic void stage_text(string s);
    for (int i = 0; i < PatternBytes; i++) begin
      staged_pat[i] = (i < s.len()) ? s[i] : 8'($urandom_range(0, 255));
    end
  endfunction

  function automatic void name_from(string s);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
  endfunction

  function automatic void put_pat(logic [ByteW-1:0] b);
    if (staged_len < PatternBytes) begin
      staged_pat[staged_len] = b;
      staged_len++;
    end
  endfunction

  // mostly a few lowercase letters so that names and patterns meet often
  function automatic logic [ByteW-1:0] rand_name_byte();
    if ($urandom_range(0, 3) != 0) return LetterA + 8'($urandom_range(0, 4));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [ByteW-1:0] rand_meta();
    case ($urandom_range(0, 6))
      0: return ChEsc;
      1: return ChAny;
      2: return ChStar;
      3: return ChOpen;
      4: return ChNot;
      5: return ChClose;
      default: return ChDash;
    endcase
  endfunction

  // fill the staging area element by element; bytes past the end stay random
  function automatic void random_pattern(int unsigned target);
    staged_len = 0;
    for (int i = 0; i < PatternBytes; i++) staged_pat[i] = 8'($urandom_range(0, 255));
    while (staged_len < target) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: put_pat(rand_name_byte());
        4: put_pat(8'($urandom_range(0, 255)));
        5: put_pat(ChAny);
        6: put_pat(ChStar);
        7: begin
          put_pat(ChStar);
          put_pat(ChStar);
        end
        8: begin
          put_pat(ChEsc);
          put_pat(($urandom_range(0, 1) == 0) ? rand_meta() : rand_name_byte());
        end
        default: begin
          // bracket class, sometimes inverted, sometimes left open
          put_pat(ChOpen);
          if ($urandom_range(0, 2) == 0) put_pat(ChNot);
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
              0: put_pat(rand_name_byte());
              1: begin
                put_pat(rand_name_byte());
                put_pat(ChDash);
                put_pat(rand_name_byte());
              end
              2: put_pat(ChDash);
              default: put_pat(8'($urandom_range(0, 255)));
            endcase
          end
          if ($urandom_range(0, 7) != 0) put_pat(ChClose);
        end
      endcase
    end
  endfunction

  // walk the staged pattern and build a name that should mostly fit it
  function automatic void compose_name(int unsigned len);
    int unsigned      i, j;
    logic [ByteW-1:0] p;
    name_buf.delete();
    i = 0;
    while (i < len) begin
      p = staged_pat[i];
      if (p == ChEsc) begin
        if (i + 1 < len) name_buf.push_back(staged_pat[i + 1]);
        i += 2;
      end else if (p == ChAny) begin
        name_buf.push_back(8'($urandom_range(0, 255)));
        i++;
      end else if (p == ChStar) begin
        repeat ($urandom_range(0, 3)) name_buf.push_back(rand_name_byte());
        i++;
      end else if (p == ChOpen) begin
        j = i + 1;
        while (j < len && staged_pat[j] != ChClose) j++;
        if (j > i + 1 && $urandom_range(0, 3) != 0) begin
          name_buf.push_back(staged_pat[$urandom_range(i + 1, j - 1)]);
        end else begin
          name_buf.push_back(rand_name_byte());
        end
        i = (j < len) ? j + 1 : j;
      end else begin
        name_buf.push_back(p);
        i++;
      end
    end
    // disturb some of them
    case ($urandom_range(0, 7))
      0: if (name_buf.size() != 0) name_buf[$urandom_range(0, name_buf.size() - 1)] = rand_name_byte();
      1: if (name_buf.size() != 0) name_buf.delete($urandom_range(0, name_buf.size() - 1));
      2: name_buf.push_back(rand_name_byte());
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // pattern registers still at reset: empty pattern
  task automatic test_reset_state();
    name_buf.delete();
    send_name_buf();                        // empty name matches an empty pattern
    push_word(8'h00, 1'b0, 1'b0);           // idle word, no effect
    push_word(8'hFF, 1'b1, 1'b1);           // byte with the pattern used up
  endtask

  task automatic test_escape_and_any();
    drain_block();
    stage_text("\\*?");
    commit_pattern(3);
    name_buf = '{ChStar, 8'h00};
    send_name_buf();
    // backslash as the final pattern byte
    drain_block();
    stage_text("?\\");
    commit_pattern(2);
    name_from("a*");
    send_name_buf();
  endtask

  task automatic test_stars();
    drain_block();
    stage_text("a*c*");
    commit_pattern(4);
    name_from("abxc");                      // search, then trailing star at name end
    send_name_buf();
    drain_block();
    stage_text("a*c");
    commit_pattern(3);
    name_from("ab");                        // name ends while the star still searches
    send_name_buf();
    drain_block();
    stage_text("a**");
    commit_pattern(3);
    name_from("ab");                        // double star decides with supermatch
    send_name_buf();
  endtask

  task automatic test_classes();
    drain_block();
    stage_text("[!a-c-]");                  // dash after a range is literal
    commit_pattern(7);
    name_from("-");
    send_name_buf();
    name_from("d");
    send_name_buf();
    drain_block();
    stage_text("[-a][ab");                  // leading dash, then an unclosed class
    commit_pattern(7);
    name_from("-b");
    send_name_buf();
  endtask

  task automatic test_byte_extremes();
    drain_block();
    stage_text("[\001-\376]");              // unsigned range over the byte span
    commit_pattern(5);
    name_buf = '{8'h80};
    send_name_buf();
    name_buf = '{8'hFF};
    send_name_buf();
    name_buf = '{8'h00};
    send_name_buf();
    // length above the buffer saturates: 'a' then stars up to the last byte
    drain_block();
    staged_pat[0] = LetterA;
    for (int i = 1; i < PatternBytes; i++) staged_pat[i] = ChStar;
    commit_pattern({LenW{1'b1}});
    name_from("a");
    send_name_buf();
    name_from("ab");
    send_name_buf();
  endtask

  task automatic test_random_names();
    int unsigned      sent, phase_goal, target, len_used;
    logic [LenW-1:0]  len_val;
    sent = 0;
    while (sent < RandomWords) begin
      drain_block();
      // mostly short patterns, now and then one near the buffer size
      target = ($urandom_range(0, 7) == 0) ? $urandom_range(20, PatternBytes)
                                           : $urandom_range(1, 10);
      random_pattern(target);
      case ($urandom_range(0, 15))
        0: len_val = LenW'($urandom_range(0, (1 << LenW) - 1));
        1: len_val = {LenW{1'b1}};
        2: len_val = '0;
        3: len_val = LenW'(PatternBytes);
        default: len_val = LenW'(staged_len);
      endcase
      commit_pattern(len_val);
      len_used      = eff_len(len_val);
      steady_sender = ($urandom_range(0, 3) == 0);
      idle_noise    = $urandom_range(0, 1);
      phase_goal    = sent + $urandom_range(40, 160);
      while (sent < phase_goal && sent < RandomWords) begin
        if ($urandom_range(0, 3) != 0) begin
          compose_name(len_used);
        end else begin
          name_buf.delete();
          repeat ($urandom_range(0, 8)) name_buf.push_back(rand_name_byte());
        end
        sent += (name_buf.size() == 0) ? 1 : name_buf.size();
        send_name_buf();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // result check: each result word against the oldest pending verdict
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        flag_error($sformatf("result %0d: none expected, got match %b supermatch %b",
                             verdicts_seen, result_if.match, result_if.supermatch));
      end else begin
        want = expected_verdicts.pop_front();
        if (result_if.match !== want.match) begin
          flag_error($sformatf("result %0d: match expected %b got %b",
                               verdicts_seen, want.match, result_if.match));
        end
        if (result_if.supermatch !== want.supermatch) begin
          flag_error($sformatf("result %0d: supermatch expected %b got %b",
                               verdicts_seen, want.supermatch, result_if.supermatch));
        end
      end
    end
  end

  // receiver ready follows a randomly chosen pattern, chosen anew when its span runs out
  initial begin : result_stall
    rx_mode_e    mode;
    int unsigned span;
    result_if.ready = 1'b0;
    mode = RxOpen;
    span = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        span = $urandom_range(50, 400);
      end
      span--;
      case (mode)
        RxOpen:     result_if.ready <= 1'b1;
        RxRandom:   result_if.ready <= ($urandom_range(0, 3) != 0);
        RxPeriodic: result_if.ready <= ((span % 6) < 2);
        default:    result_if.ready <= ($urandom_range(0, 15) == 0);  // long stalls
      endcase
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < MaxCycles) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    // every block input known from time zero
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    name_if.valid     = 1'b0;
    name_if.name_byte = '0;
    name_if.has_byte  = 1'b0;
    name_if.last      = 1'b0;

    // model starts from the reset state
    for (int w = 0; w < NumWords; w++) pat_word_q[w] = '0;
    pat_len_q     = '0;
    cur_pos       = 0;
    star_seeking  = 1'b0;
    decided       = 1'b0;
    dec_match     = 1'b0;
    dec_super     = 1'b0;
    error_count   = 0;
    verdicts_seen = 0;
    burst_left    = 0;
    steady_sender = 1'b0;
    idle_noise    = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_escape_and_any();
    test_stars();
    test_classes();
    test_byte_extremes();
    test_random_names();

    drain_block();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
